// File: hdl/assert_macros.svh
// assertion helpers for the rtl, clocked on clk and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TTM_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TTM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/ttm_pkg.sv
package ttm_pkg;

	localparam int TIMER_SLOTS   = 16;
	localparam int OWNER_BITS    = 8;
	localparam int EVENT_BITS    = 16;
	localparam int IVL_BITS      = 32;
	localparam int TIME_BITS     = 48;
	localparam int OP_BITS       = 3;
	localparam int STATUS_BITS   = 3;
	localparam int SLOT_IDX_BITS = $clog2(TIMER_SLOTS);

	typedef enum logic [OP_BITS-1:0] {
		OP_TICK       = 3'd0,
		OP_SET        = 3'd1,
		OP_KILL_ONE   = 3'd2,
		OP_KILL_OWNER = 3'd3,
		OP_KILL_ALL   = 3'd4
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_DONE      = 3'd0,
		ST_FIRED     = 3'd1,
		ST_REJECTED  = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN2,
		S_FIN
	} state_t;

	typedef struct packed {
		logic                  valid;
		logic [OWNER_BITS-1:0] owner;
		logic [EVENT_BITS-1:0] evt_id;
		logic [IVL_BITS-1:0]   interval;
		logic                  periodic;
		logic [TIME_BITS-1:0]  deadline;
	} slot_t;

	typedef struct packed {
		logic [OWNER_BITS-1:0] owner;
		logic [EVENT_BITS-1:0] evt_id;
		logic [IVL_BITS-1:0]   interval;
		logic                  periodic;
	} req_t;

	typedef struct packed {
		logic fire;
		logic match;
		logic free;
	} flag_t;

endpackage

// File: hdl/ttm_cell.sv
module ttm_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  ttm_pkg::slot_t  d,
	output ttm_pkg::slot_t  q
);

	logic                           valid_q;
	logic [ttm_pkg::OWNER_BITS-1:0] owner_q;
	logic [ttm_pkg::EVENT_BITS-1:0] evt_id_q;
	logic [ttm_pkg::IVL_BITS-1:0]   interval_q;
	logic                           periodic_q;
	logic [ttm_pkg::TIME_BITS-1:0]  deadline_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			owner_q    <= d.owner;
			evt_id_q   <= d.evt_id;
			interval_q <= d.interval;
			periodic_q <= d.periodic;
			deadline_q <= d.deadline;
		end
	end

	assign q = '{valid: valid_q, owner: owner_q, evt_id: evt_id_q, interval: interval_q,
		periodic: periodic_q, deadline: deadline_q};

endmodule

// File: hdl/ttm_proc.sv
module ttm_proc (
	input  logic [ttm_pkg::OP_BITS-1:0]   op,
	input  logic                          second_pass,
	input  logic                          at_target,
	input  ttm_pkg::req_t                 req,
	input  logic [ttm_pkg::TIME_BITS-1:0] now,
	input  ttm_pkg::slot_t                head,
	output ttm_pkg::slot_t                nxt,
	output ttm_pkg::flag_t                flags
);

	logic owner_eq;
	logic evt_eq;

	assign owner_eq = head.owner == req.owner;
	assign evt_eq   = head.evt_id == req.evt_id;

	always_comb begin
		nxt         = head;
		flags.fire  = 1'b0;
		flags.match = 1'b0;
		flags.free  = !head.valid;
		unique case (op)
			ttm_pkg::OP_TICK: begin
				flags.fire = head.valid && (head.deadline <= now);
				if (flags.fire) begin
					if (head.periodic) begin
						nxt.deadline = now + ttm_pkg::TIME_BITS'(head.interval);
					end else begin
						nxt.valid = 1'b0;
					end
				end
			end
			ttm_pkg::OP_SET: begin
				flags.match = head.valid && owner_eq && evt_eq;
				// second lap writes the chosen slot as it passes the head
				if (second_pass && at_target) begin
					nxt.valid    = 1'b1;
					nxt.owner    = req.owner;
					nxt.evt_id   = req.evt_id;
					nxt.interval = req.interval;
					nxt.periodic = req.periodic;
					nxt.deadline = now + ttm_pkg::TIME_BITS'(req.interval);
				end
			end
			ttm_pkg::OP_KILL_ONE: begin
				flags.match = head.valid && owner_eq && evt_eq;
				if (flags.match) begin
					nxt.valid = 1'b0;
				end
			end
			ttm_pkg::OP_KILL_OWNER: begin
				flags.match = head.valid && owner_eq;
				if (flags.match) begin
					nxt.valid = 1'b0;
				end
			end
			ttm_pkg::OP_KILL_ALL: begin
				nxt.valid = 1'b0;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: hdl/timer_table_manager_core.sv
// timer table: a ring of timer slot cells that rotates one slot per cycle past a
// single head unit, which tests, fires, kills or writes the slot at the head.
// request channel: in_valid/in_ready with operation, owner, event_id, interval,
// periodic; in_ready is high only while no request is in progress.
// result channel: out_valid/out_ready with status, fired_owner, fired_event, last;
// every request ends with exactly one result that has last set.
// tick, kill one, kill owner and kill all take one lap of the ring, then the
// final result is issued from the fin state and the block returns to idle.
// set takes two laps (search, then write of the chosen slot); a set on a
// full table stops after the search lap.
// rejected and unknown requests skip the ring and go straight to the fin state.
// fired timers of a tick leave in slot order; one is held back so that the
// last one can carry the last flag.
// a result register parts the two channels; when it is still full the lap
// pauses at the next fired timer and the ring holds until out_ready.
// reset clears time, every slot valid bit and both handshakes; slot contents
// are not cleared and the block takes a request in the first cycle after reset.
`include "assert_macros.svh"

module timer_table_manager_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ttm_pkg::OP_BITS-1:0]     operation,
	input  logic [ttm_pkg::OWNER_BITS-1:0]  owner,
	input  logic [ttm_pkg::EVENT_BITS-1:0]  event_id,
	input  logic [ttm_pkg::IVL_BITS-1:0]    interval,
	input  logic                            periodic,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ttm_pkg::STATUS_BITS-1:0] status,
	output logic [ttm_pkg::OWNER_BITS-1:0]  fired_owner,
	output logic [ttm_pkg::EVENT_BITS-1:0]  fired_event,
	output logic                            last
);

	ttm_pkg::state_t                    state_q, state_d;
	logic [ttm_pkg::OP_BITS-1:0]        op_q;
	ttm_pkg::req_t                      req_q;
	logic                               bad_q;
	logic [ttm_pkg::SLOT_IDX_BITS-1:0]  cnt_q;
	logic [ttm_pkg::TIME_BITS-1:0]      now_q;
	logic                               hit_q, free_q, any_q;
	logic [ttm_pkg::SLOT_IDX_BITS-1:0]  hit_idx_q, free_idx_q;
	logic                               pend_valid_q;
	logic [ttm_pkg::OWNER_BITS-1:0]     pend_owner_q;
	logic [ttm_pkg::EVENT_BITS-1:0]     pend_event_q;
	logic                               out_valid_q;
	logic [ttm_pkg::STATUS_BITS-1:0]    status_q;
	logic [ttm_pkg::OWNER_BITS-1:0]     owner_out_q;
	logic [ttm_pkg::EVENT_BITS-1:0]     event_out_q;
	logic                               last_q;

	ttm_pkg::slot_t                     ring [ttm_pkg::TIMER_SLOTS];
	ttm_pkg::slot_t                     proc_nxt;
	ttm_pkg::flag_t                     flags;
	ttm_pkg::req_t                      req_in;

	logic                               accept, req_bad, op_known, direct_fin;
	logic                               out_free, shift, scan_emit, fin_load, cnt_last;
	logic                               at_target;
	logic [ttm_pkg::SLOT_IDX_BITS-1:0]  tgt_idx;
	logic [ttm_pkg::STATUS_BITS-1:0]    fin_status;
	logic [ttm_pkg::OWNER_BITS-1:0]     fin_owner;
	logic [ttm_pkg::EVENT_BITS-1:0]     fin_event;

	assign req_in   = '{owner: owner, evt_id: event_id, interval: interval, periodic: periodic};
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign cnt_last = cnt_q == ttm_pkg::SLOT_IDX_BITS'(ttm_pkg::TIMER_SLOTS - 1);
	assign tgt_idx  = hit_q ? hit_idx_q : free_idx_q;
	assign at_target = cnt_q == tgt_idx;
	assign req_bad  = (owner == '0) || (event_id == '0) || (interval == '0);

	// slot ring: cell i takes from cell i+1, the tail takes the head's update
	for (genvar i = 0; i < ttm_pkg::TIMER_SLOTS; i++) begin : g_cell
		ttm_pkg::slot_t d;
		if (i == ttm_pkg::TIMER_SLOTS - 1) begin : g_tail
			assign d = proc_nxt;
		end else begin : g_mid
			assign d = ring[i+1];
		end
		ttm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.d      (d),
			.q      (ring[i])
		);
	end

	ttm_proc u_proc (
		.op          (op_q),
		.second_pass (state_q == ttm_pkg::S_SCAN2),
		.at_target   (at_target),
		.req         (req_q),
		.now         (now_q),
		.head        (ring[0]),
		.nxt         (proc_nxt),
		.flags       (flags)
	);

	always_comb begin
		unique case (operation)
			ttm_pkg::OP_TICK, ttm_pkg::OP_SET, ttm_pkg::OP_KILL_ONE,
			ttm_pkg::OP_KILL_OWNER, ttm_pkg::OP_KILL_ALL: op_known = 1'b1;
			default: op_known = 1'b0;
		endcase
		direct_fin = !op_known || (operation == ttm_pkg::OP_SET && req_bad);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		shift     = 1'b0;
		scan_emit = 1'b0;
		fin_load  = 1'b0;
		unique case (state_q)
			ttm_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = direct_fin ? ttm_pkg::S_FIN : ttm_pkg::S_SCAN;
				end
			end
			ttm_pkg::S_SCAN: begin
				// a second fired timer must push the held one out first
				if (op_q == ttm_pkg::OP_TICK && flags.fire && pend_valid_q) begin
					shift     = out_free;
					scan_emit = out_free;
				end else begin
					shift = 1'b1;
				end
				if (shift && cnt_last) begin
					if (op_q == ttm_pkg::OP_SET &&
						(hit_q || flags.match || free_q || flags.free)) begin
						state_d = ttm_pkg::S_SCAN2;
					end else begin
						state_d = ttm_pkg::S_FIN;
					end
				end
			end
			ttm_pkg::S_SCAN2: begin
				shift = 1'b1;
				if (cnt_last) begin
					state_d = ttm_pkg::S_FIN;
				end
			end
			ttm_pkg::S_FIN: begin
				if (out_free) begin
					fin_load = 1'b1;
					state_d  = ttm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ttm_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		fin_status = ttm_pkg::ST_DONE;
		fin_owner  = '0;
		fin_event  = '0;
		unique case (op_q)
			ttm_pkg::OP_TICK: begin
				if (pend_valid_q) begin
					fin_status = ttm_pkg::ST_FIRED;
					fin_owner  = pend_owner_q;
					fin_event  = pend_event_q;
				end
			end
			ttm_pkg::OP_SET: begin
				fin_event = req_q.evt_id;
				if (bad_q) begin
					fin_status = ttm_pkg::ST_REJECTED;
				end else if (!(hit_q || free_q)) begin
					fin_status = ttm_pkg::ST_FULL;
				end
			end
			ttm_pkg::OP_KILL_ONE, ttm_pkg::OP_KILL_OWNER: begin
				fin_status = any_q ? ttm_pkg::ST_DONE : ttm_pkg::ST_NOT_FOUND;
			end
			ttm_pkg::OP_KILL_ALL: begin
				fin_status = ttm_pkg::ST_DONE;
			end
			default: begin
				fin_status = ttm_pkg::ST_REJECTED;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q         <= ttm_pkg::OP_TICK;
			bad_q        <= 1'b0;
			cnt_q        <= '0;
			now_q        <= '0;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
			any_q        <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				op_q         <= operation;
				bad_q        <= req_bad;
				cnt_q        <= '0;
				hit_q        <= 1'b0;
				free_q       <= 1'b0;
				any_q        <= 1'b0;
				pend_valid_q <= 1'b0;
				if (operation == ttm_pkg::OP_TICK) begin
					now_q <= now_q + ttm_pkg::TIME_BITS'(1);
				end
			end
			if (shift) begin
				cnt_q <= cnt_last ? '0 : cnt_q + ttm_pkg::SLOT_IDX_BITS'(1);
				if (state_q == ttm_pkg::S_SCAN) begin
					if (flags.match) begin
						hit_q <= 1'b1;
						any_q <= 1'b1;
					end
					if (flags.free) begin
						free_q <= 1'b1;
					end
					if (op_q == ttm_pkg::OP_TICK && flags.fire) begin
						pend_valid_q <= 1'b1;
					end
				end
			end
			if (scan_emit || fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_in;
		end
		if (shift && state_q == ttm_pkg::S_SCAN) begin
			if (flags.match && !hit_q) begin
				hit_idx_q <= cnt_q;
			end
			if (flags.free && !free_q) begin
				free_idx_q <= cnt_q;
			end
			if (op_q == ttm_pkg::OP_TICK && flags.fire) begin
				pend_owner_q <= ring[0].owner;
				pend_event_q <= ring[0].evt_id;
			end
		end
		if (scan_emit) begin
			status_q    <= ttm_pkg::ST_FIRED;
			owner_out_q <= pend_owner_q;
			event_out_q <= pend_event_q;
			last_q      <= 1'b0;
		end else if (fin_load) begin
			status_q    <= fin_status;
			owner_out_q <= fin_owner;
			event_out_q <= fin_event;
			last_q      <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign fired_owner = owner_out_q;
	assign fired_event = event_out_q;
	assign last        = last_q;

	`TTM_ASSERT_IMPL(a_fired_has_owner, out_valid && status == ttm_pkg::ST_FIRED, fired_owner != '0, "fired result without owner")
	`TTM_ASSERT_IMPL(a_idle_cnt_zero, state_q == ttm_pkg::S_IDLE, cnt_q == '0, "slot counter not parked at zero while idle")
	`TTM_ASSERT_NEXT(a_tick_advances_time, accept && operation == ttm_pkg::OP_TICK, now_q == $past(now_q) + ttm_pkg::TIME_BITS'(1), "tick did not advance time by one")
	`TTM_ASSERT_IMPL(a_pending_only_on_tick, pend_valid_q, op_q == ttm_pkg::OP_TICK, "held fired timer outside a tick")

endmodule
